// ----- rtl/core/rlps_pkg.sv -----
// Shared widths, constants, register codes and reset values for the Ricker
// log-population stepper. No dependencies; used by the channel interfaces
// and by the top level.
package rlps_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned SCALE_W     = 31;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned STEP_W      = 17;
   localparam int unsigned REG_INDEX_W = 3;
   localparam int unsigned MUL_W       = 33;
   localparam int unsigned PROD_W      = 2 * MUL_W;
   localparam int unsigned KEXP_W      = 17;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned POLY_W      = 18;
   localparam int unsigned EXP_W       = 31;

   // log2(e) in Q16.16 and the Horner coefficients of 2^f on [0,1)
   localparam int unsigned LOG2E_Q16 = 94548;
   localparam int unsigned EXP_C1    = 45559;
   localparam int unsigned EXP_C2    = 14821;
   localparam int unsigned EXP_C3    = 5179;
   localparam int unsigned Q16_ONE   = 65536;

   localparam logic [DATA_W-1:0]  LOG_GROWTH_RATE_RST = 32'd196608;
   localparam logic [SCALE_W-1:0] NOISE_SCALE_RST     = 31'd19661;
   localparam logic [DATA_W-1:0]  INITIAL_LOG_POP_RST = 32'd65536;
   localparam logic [COUNT_W-1:0] BURN_IN_STEPS_RST   = 16'd50;
   localparam logic [COUNT_W-1:0] KEPT_STEPS_RST      = 16'd100;
   localparam logic [COUNT_W-1:0] REPLICATE_COUNT_RST = 16'd1;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_LOG_GROWTH_RATE = 3'd0,
      REG_NOISE_SCALE     = 3'd1,
      REG_INITIAL_LOG_POP = 3'd2,
      REG_BURN_IN_STEPS   = 3'd3,
      REG_KEPT_STEPS      = 3'd4,
      REG_REPLICATE_COUNT = 3'd5
   } csr_reg_type;

endpackage

// ----- rtl/core/rlps_if.sv -----
// Valid/ready channel interfaces of the Ricker log-population stepper:
// noise request, result response and register write channel.
// Depends on rlps_pkg for field widths.
interface rlps_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rlps_pkg::DATA_W-1:0]  noise;

   modport source (output valid, output noise, input ready);
   modport sink   (input valid, input noise, output ready);
endinterface

interface rlps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rlps_pkg::DATA_W-1:0]  log_pop;
   logic                                last_in_replicate;
   logic                                last_of_all;

   modport source (output valid, output log_pop, output last_in_replicate,
                   output last_of_all, input ready);
   modport sink   (input valid, input log_pop, input last_in_replicate,
                   input last_of_all, output ready);
endinterface

interface rlps_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [rlps_pkg::REG_INDEX_W-1:0]      index;
   logic [rlps_pkg::DATA_W-1:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/ricker_log_population_stepper.sv -----
// Ricker log-population stepper: one stochastic Ricker map step per noise
// transaction. Depends on rlps_pkg and the channel interfaces in rlps_if.sv.
//
// Usage:
//  - req_if carries one signed Q16.16 noise sample per transaction. Each one
//    advances x <- x + log_growth_rate - exp(x) + noise*noise_scale (Q16.16,
//    saturating); every replicate restarts from initial_log_pop.
//  - rsp_if carries log_pop for each kept step, with last_in_replicate on the
//    final kept step of a replicate and last_of_all on that of the final
//    replicate. Burn-in steps produce no rsp transaction.
//  - csr_if writes register <index> with <data>; it is always ready. Write
//    only while the block is idle. Unknown indexes are ignored.
//  - Sequencing: an accepted noise transaction runs the sequencer through
//    six steps (S_LOG2E, S_POLY1, S_POLY2, S_POLY3, S_NOISE, S_SUM); a new
//    one is taken only after it returns to S_IDLE. All products share one
//    33x33 signed multiplier: the log2(e) scaling, three Horner products of
//    2^f and the noise product; the last step forms the saturated sum.
//    req_if.ready is high only while the sequencer is idle.
//  - A result sits in an output register; a new sample is accepted while it
//    waits. If the receiver still stalls when the next result is due, the
//    sequencer holds in its final step until the register frees.
//  - Reset (synchronous, active high) restores register defaults, clears the
//    step and replicate counters and empties the output register.
module ricker_log_population_stepper (
   input  logic        clock,
   input  logic        reset,
   rlps_req_if.sink    req_if,
   rlps_rsp_if.source  rsp_if,
   rlps_csr_if.sink    csr_if
);

   localparam int unsigned DATA_W  = rlps_pkg::DATA_W;
   localparam int unsigned MUL_W   = rlps_pkg::MUL_W;
   localparam int unsigned PROD_W  = rlps_pkg::PROD_W;
   localparam int unsigned KEXP_W  = rlps_pkg::KEXP_W;
   localparam int unsigned FRAC_W  = rlps_pkg::FRAC_W;
   localparam int unsigned POLY_W  = rlps_pkg::POLY_W;
   localparam int unsigned EXP_W   = rlps_pkg::EXP_W;
   localparam int unsigned STEP_W  = rlps_pkg::STEP_W;
   localparam int unsigned COUNT_W = rlps_pkg::COUNT_W;
   localparam int unsigned SUM_W   = 49;
   localparam int unsigned NTERM_W = 47;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LOG2E = 7'b0000010,
      S_POLY1 = 7'b0000100,
      S_POLY2 = 7'b0001000,
      S_POLY3 = 7'b0010000,
      S_NOISE = 7'b0100000,
      S_SUM   = 7'b1000000
   } state_type;

   // configuration
   logic signed [DATA_W-1:0]            log_growth_rate_ff;
   logic [rlps_pkg::SCALE_W-1:0]        noise_scale_ff;
   logic signed [DATA_W-1:0]            initial_log_pop_ff;
   logic [COUNT_W-1:0]                  burn_in_steps_ff;
   logic [COUNT_W-1:0]                  kept_steps_ff;
   logic [COUNT_W-1:0]                  replicate_count_ff;

   state_type                           state_ff, state_in;
   logic [STEP_W-1:0]                   step_ff, step_in;
   logic [COUNT_W-1:0]                  rep_ff, rep_in;
   logic signed [DATA_W-1:0]            log_pop_ff, log_pop_in;
   logic signed [DATA_W-1:0]            noise_ff;
   logic signed [PROD_W-1:0]            prod_ff, prod_in;
   logic signed [KEXP_W-1:0]            k_ff;
   logic [FRAC_W-1:0]                   f_ff;
   logic [EXP_W-1:0]                    exp_ff, exp_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]            rsp_log_pop_ff;
   logic                                rsp_last_rep_ff;
   logic                                rsp_last_all_ff;

   logic signed [MUL_W-1:0]             mul_a, mul_b;
   logic [POLY_W-1:0]                   poly_p;
   logic [KEXP_W-1:0]                   k_neg;
   logic [MUL_W-1:0]                    exp_shl;
   logic signed [SUM_W-1:0]             sum_wide;
   logic signed [DATA_W-1:0]            sum_sat;
   logic [COUNT_W-1:0]                  kept_eff, reps_eff;
   logic [STEP_W-1:0]                   last_step;
   logic                                emit, end_rep, end_all;
   logic                                out_free, sum_go, req_take;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_take     = req_if.valid && req_if.ready;

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.log_pop           = rsp_log_pop_ff;
   assign rsp_if.last_in_replicate = rsp_last_rep_ff;
   assign rsp_if.last_of_all       = rsp_last_all_ff;

   // ---------------- shared multiplier ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_LOG2E: begin
            mul_a = MUL_W'(log_pop_ff);
            mul_b = MUL_W'(rlps_pkg::LOG2E_Q16);
         end
         S_POLY1: begin
            mul_a = MUL_W'(rlps_pkg::EXP_C3);
            mul_b = MUL_W'(prod_ff[31:16]);
         end
         S_POLY2: begin
            mul_a = MUL_W'(rlps_pkg::EXP_C2) + MUL_W'(prod_ff[33:16]);
            mul_b = MUL_W'(f_ff);
         end
         S_POLY3: begin
            mul_a = MUL_W'(rlps_pkg::EXP_C1) + MUL_W'(prod_ff[33:16]);
            mul_b = MUL_W'(f_ff);
         end
         S_NOISE: begin
            mul_a = MUL_W'(noise_ff);
            mul_b = $signed(MUL_W'(noise_scale_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // ---------------- exp from 2^f and integer part k ----------------
   assign poly_p  = POLY_W'(rlps_pkg::Q16_ONE) + POLY_W'(prod_ff[33:16]);
   assign k_neg   = -k_ff;
   assign exp_shl = MUL_W'(poly_p) << k_ff[3:0];

   always_comb begin
      if (k_ff >= 17'sd15) begin
         exp_in = '1;
      end else if (k_ff <= -17'sd18) begin
         exp_in = '0;
      end else if (!k_ff[KEXP_W-1]) begin
         exp_in = (exp_shl[MUL_W-1:EXP_W] != '0) ? '1 : exp_shl[EXP_W-1:0];
      end else begin
         exp_in = EXP_W'(poly_p >> k_neg[4:0]);
      end
   end

   // ---------------- sum, saturation, counters ----------------
   assign sum_wide = SUM_W'(log_pop_ff) + SUM_W'(log_growth_rate_ff)
                   - $signed(SUM_W'(exp_ff))
                   + SUM_W'($signed(prod_ff[NTERM_W+15:16]));

   always_comb begin
      if (sum_wide[SUM_W-1:DATA_W-1] == '0 || sum_wide[SUM_W-1:DATA_W-1] == '1) begin
         sum_sat = sum_wide[DATA_W-1:0];
      end else if (sum_wide[SUM_W-1]) begin
         sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   assign kept_eff  = (kept_steps_ff == '0) ? COUNT_W'(1) : kept_steps_ff;
   assign reps_eff  = (replicate_count_ff == '0) ? COUNT_W'(1) : replicate_count_ff;
   assign last_step = STEP_W'(burn_in_steps_ff) + STEP_W'(kept_eff) - STEP_W'(1);
   assign emit      = step_ff >= STEP_W'(burn_in_steps_ff);
   assign end_rep   = step_ff >= last_step;
   assign end_all   = end_rep && (rep_ff >= reps_eff - COUNT_W'(1));
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign sum_go    = (state_ff == S_SUM) && (!emit || out_free);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      rep_in     = rep_ff;
      log_pop_in = log_pop_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in   = S_LOG2E;
               // each replicate restarts from the configured value
               log_pop_in = (step_ff == '0) ? initial_log_pop_ff : log_pop_ff;
            end
         end
         S_LOG2E: state_in = S_POLY1;
         S_POLY1: state_in = S_POLY2;
         S_POLY2: state_in = S_POLY3;
         S_POLY3: state_in = S_NOISE;
         S_NOISE: state_in = S_SUM;
         S_SUM: begin
            if (sum_go) begin
               state_in   = S_IDLE;
               log_pop_in = sum_sat;
               if (end_rep) begin
                  step_in = '0;
                  rep_in  = end_all ? '0 : rep_ff + COUNT_W'(1);
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (sum_go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_growth_rate_ff <= rlps_pkg::LOG_GROWTH_RATE_RST;
         noise_scale_ff     <= rlps_pkg::NOISE_SCALE_RST;
         initial_log_pop_ff <= rlps_pkg::INITIAL_LOG_POP_RST;
         burn_in_steps_ff   <= rlps_pkg::BURN_IN_STEPS_RST;
         kept_steps_ff      <= rlps_pkg::KEPT_STEPS_RST;
         replicate_count_ff <= rlps_pkg::REPLICATE_COUNT_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (rlps_pkg::csr_reg_type'(csr_if.index))
            rlps_pkg::REG_LOG_GROWTH_RATE: log_growth_rate_ff <= csr_if.data;
            rlps_pkg::REG_NOISE_SCALE:
               noise_scale_ff <= csr_if.data[rlps_pkg::SCALE_W-1:0];
            rlps_pkg::REG_INITIAL_LOG_POP: initial_log_pop_ff <= csr_if.data;
            rlps_pkg::REG_BURN_IN_STEPS:   burn_in_steps_ff <= csr_if.data[COUNT_W-1:0];
            rlps_pkg::REG_KEPT_STEPS:      kept_steps_ff <= csr_if.data[COUNT_W-1:0];
            rlps_pkg::REG_REPLICATE_COUNT:
               replicate_count_ff <= csr_if.data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      log_pop_ff <= log_pop_in;
      // the noise product must survive while the sum waits for the output
      if (state_ff != S_SUM) begin
         prod_ff <= prod_in;
      end
      if (req_take) begin
         noise_ff <= req_if.noise;
      end
      if (state_ff == S_POLY1) begin
         k_ff <= prod_ff[KEXP_W+31:32];
         f_ff <= prod_ff[31:16];
      end
      if (state_ff == S_NOISE) begin
         exp_ff <= exp_in;
      end
      if (sum_go && emit) begin
         rsp_log_pop_ff  <= sum_sat;
         rsp_last_rep_ff <= end_rep;
         rsp_last_all_ff <= end_all;
      end
   end

   // ---------------- assertions ----------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_LOG2E)
      else $error("accepted transaction did not start the sequencer");

   a_last_all_implies_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_last_all_ff || rsp_last_rep_ff))
      else $error("last_of_all without last_in_replicate");

   a_replicate_end_clears_step: assert property (@(posedge clock) disable iff (reset)
      (sum_go && end_rep) |=> step_ff == '0)
      else $error("step counter not cleared at end of replicate");

   a_exp_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && k_ff <= -17'sd18) |-> exp_ff == '0)
      else $error("exp not flushed to zero for large negative exponent");

   a_exp_saturate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && k_ff >= 17'sd15) |-> exp_ff == '1)
      else $error("exp not saturated for large positive exponent");

endmodule

// ----- dv/ricker_log_population_stepper_test.sv -----
// Self-checking testbench for the Ricker log-population stepper: predicts each
// kept step in Q16.16 and checks the response channel with random idling.
// Depends on rlps_pkg, the channel interfaces in rlps_if.sv and the top level.
module ricker_log_population_stepper_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DATA_W      = rlps_pkg::DATA_W;
   localparam int unsigned SCALE_W     = rlps_pkg::SCALE_W;
   localparam int unsigned COUNT_W     = rlps_pkg::COUNT_W;
   localparam int unsigned REG_INDEX_W = rlps_pkg::REG_INDEX_W;

   localparam int IDLE_PCT      = 32;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_CYCLES  = 300;
   localparam logic signed [DATA_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q16_MIN = 32'sh8000_0000;
   // indexes with no register behind them
   localparam logic [REG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [REG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

   typedef struct {
      logic signed [DATA_W-1:0]  growth;
      logic        [SCALE_W-1:0] scale;
      logic signed [DATA_W-1:0]  start;
      logic        [COUNT_W-1:0] burn;
      logic        [COUNT_W-1:0] kept;
      logic        [COUNT_W-1:0] reps;
   } pop_cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] log_pop;
      logic                     last_rep;
      logic                     last_all;
   } pop_result_type;

   logic clock;
   logic reset;

   rlps_req_if req_ch();
   rlps_rsp_if rsp_ch();
   rlps_csr_if csr_ch();

   ricker_log_population_stepper i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // predictor state and register shadow
   pop_cfg_type              cfg_now;
   logic signed [DATA_W-1:0] x_now;
   int unsigned              step_idx;
   int unsigned              rep_idx;
   pop_result_type           expected_pops[$];

   int mismatches;
   bit idle_en;
   int rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

   // fixed-length exp(x) in Q16.16, saturating high and flushing low
   function automatic longint ricker_exp(input logic signed [DATA_W-1:0] x);
      longint          prod;
      longint          k;
      longint unsigned frac;
      longint unsigned poly;
      longint unsigned r;
      prod = longint'(x) * longint'(rlps_pkg::LOG2E_Q16);
      k    = prod >>> 32;
      frac = (prod >> 16) & 64'hFFFF;
      poly = rlps_pkg::EXP_C3;
      poly = rlps_pkg::EXP_C2 + ((poly * frac) >> 16);
      poly = rlps_pkg::EXP_C1 + ((poly * frac) >> 16);
      poly = rlps_pkg::Q16_ONE + ((poly * frac) >> 16);
      if (k >= 15) return longint'(Q16_MAX);
      if (k <= -18) return 0;
      if (k >= 0) begin
         r = poly << k;
         if (r > 64'd2147483647) r = 64'd2147483647;
         return longint'(r);
      end
      return longint'(poly >> (-k));
   endfunction

   task automatic ricker_step(input logic signed [DATA_W-1:0] noise);
      int unsigned kept;
      int unsigned reps;
      int unsigned last_step;
      longint      sum;
      bit          emit;
      bit          end_rep;
      bit          end_all;
      kept      = (cfg_now.kept == '0) ? 1 : cfg_now.kept;
      reps      = (cfg_now.reps == '0) ? 1 : cfg_now.reps;
      last_step = cfg_now.burn + kept - 1;
      end_all   = 1'b0;
      if (step_idx == 0) x_now = cfg_now.start;
      sum = longint'(x_now) + longint'(cfg_now.growth) - ricker_exp(x_now)
          + ((longint'(noise) * longint'(cfg_now.scale)) >>> 16);
      if (sum > longint'(Q16_MAX)) sum = longint'(Q16_MAX);
      if (sum < longint'(Q16_MIN)) sum = longint'(Q16_MIN);
      x_now   = sum[DATA_W-1:0];
      emit    = step_idx >= cfg_now.burn;
      end_rep = step_idx >= last_step;
      if (end_rep) begin
         step_idx = 0;
         if (rep_idx >= reps - 1) begin
            end_all = 1'b1;
            rep_idx = 0;
         end else begin
            rep_idx = (rep_idx + 1) & 32'hFFFF;
         end
      end else begin
         step_idx = (step_idx + 1) & 32'h1FFFF;
      end
      if (emit) expected_pops.push_back('{x_now, end_rep, end_all});
   endtask

   // extremes, full-range values, or values within +/- spread of zero
   function automatic logic signed [DATA_W-1:0] rand_q16(input int unsigned spread);
      case ($urandom_range(0, 9))
         0:       return Q16_MIN;
         1:       return Q16_MAX;
         2, 3:    return $urandom;
         default: return $urandom_range(0, 2 * spread) - spread;
      endcase
   endfunction

   function automatic pop_cfg_type base_cfg(input int unsigned burn, input int unsigned kept,
                                            input int unsigned reps);
      pop_cfg_type c;
      c.growth = rlps_pkg::LOG_GROWTH_RATE_RST;
      c.scale  = rlps_pkg::NOISE_SCALE_RST;
      c.start  = rlps_pkg::INITIAL_LOG_POP_RST;
      c.burn   = COUNT_W'(burn);
      c.kept   = COUNT_W'(kept);
      c.reps   = COUNT_W'(reps);
      return c;
   endfunction

   // leaves valid high so that back-to-back writes need no second assignment
   task automatic csr_write(input logic [REG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         rlps_pkg::REG_LOG_GROWTH_RATE: cfg_now.growth = data;
         rlps_pkg::REG_NOISE_SCALE:     cfg_now.scale  = data[SCALE_W-1:0];
         rlps_pkg::REG_INITIAL_LOG_POP: cfg_now.start  = data;
         rlps_pkg::REG_BURN_IN_STEPS:   cfg_now.burn   = data[COUNT_W-1:0];
         rlps_pkg::REG_KEPT_STEPS:      cfg_now.kept   = data[COUNT_W-1:0];
         rlps_pkg::REG_REPLICATE_COUNT: cfg_now.reps   = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // unused upper bits get random values; they must be dropped
   task automatic apply_config(input pop_cfg_type c);
      csr_write(rlps_pkg::REG_LOG_GROWTH_RATE, c.growth);
      csr_write(rlps_pkg::REG_NOISE_SCALE, {1'($urandom), c.scale});
      csr_write(rlps_pkg::REG_INITIAL_LOG_POP, c.start);
      csr_write(rlps_pkg::REG_BURN_IN_STEPS, {16'($urandom), c.burn});
      csr_write(rlps_pkg::REG_KEPT_STEPS, {16'($urandom), c.kept});
      csr_write(rlps_pkg::REG_REPLICATE_COUNT, {16'($urandom), c.reps});
      csr_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_noise(input logic signed [DATA_W-1:0] value);
      if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (idle_en && $urandom_range(0, 99) < IDLE_PCT);
      end
      req_ch.valid <= 1'b1;
      req_ch.noise <= value;
      do @(posedge clock); while (!req_ch.ready);
      ricker_step(value);
   endtask

   // burn-in steps leave the sequencer busy after the last result, hence the settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_pops.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: check each transaction, then drive ready for the next edge
   initial begin
      pop_result_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pops.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: log_pop %h last_rep %0b last_all %0b",
                           rsp_ch.log_pop, rsp_ch.last_in_replicate, rsp_ch.last_of_all);
            end else begin
               want = expected_pops.pop_front();
               if (want.log_pop !== rsp_ch.log_pop
                   || want.last_rep !== rsp_ch.last_in_replicate
                   || want.last_all !== rsp_ch.last_of_all) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h/%0b/%0b, got %h/%0b/%0b",
                              want.log_pop, want.last_rep, want.last_all, rsp_ch.log_pop,
                              rsp_ch.last_in_replicate, rsp_ch.last_of_all);
               end
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // defaults, then counts retuned part way through a replicate
   task automatic test_reset_and_retune();
      pop_cfg_type c;
      send_noise(Q16_MAX);
      send_noise(Q16_MIN);
      wait_drained();
      c = base_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
      apply_config(c);
      send_noise('0);
      wait_drained();
      c.burn = '0;
      c.kept = COUNT_W'(1);
      apply_config(c);
      send_noise(32'sd1);
      wait_drained();
      c.reps = COUNT_W'(1);
      apply_config(c);
      send_noise(-32'sd1);
      wait_drained();
   endtask

   // kept and replicate counts of zero behave as one
   task automatic test_zero_counts();
      apply_config(base_cfg(0, 0, 0));
      send_noise(Q16_MAX);
      send_noise(Q16_MIN);
      send_noise(-32'sd1);
      wait_drained();
   endtask

   // start values around the saturation and flush limits of exp
   task automatic test_exp_limits();
      logic signed [DATA_W-1:0] starts[6];
      pop_cfg_type c;
      starts = '{Q16_MAX, Q16_MIN, 32'sd700000, 32'sd680000, -32'sd760000, -32'sd800000};
      c = base_cfg(0, 1, 1);
      c.growth = '0;
      c.scale  = '0;
      foreach (starts[i]) begin
         c.start = starts[i];
         apply_config(c);
         send_noise(rand_q16(65536));
         wait_drained();
      end
   endtask

   task automatic test_sum_saturation();
      pop_cfg_type c;
      c = base_cfg(0, 1, 1);
      c.growth = Q16_MAX;
      c.scale  = '1;
      c.start  = Q16_MAX;
      apply_config(c);
      send_noise(Q16_MAX);
      wait_drained();
      c.growth = Q16_MIN;
      c.start  = Q16_MIN;
      apply_config(c);
      send_noise(Q16_MIN);
      wait_drained();
   endtask

   // two whole replicates: reload at each start, markers, wrap to the first
   task automatic test_replicate_cycle();
      apply_config(base_cfg(2, 3, 2));
      repeat (10) send_noise(rand_q16(3 * 65536));
      wait_drained();
   endtask

   task automatic test_output_stall();
      apply_config(base_cfg(0, 7, 3));
      rsp_hold_cycles = STALL_CYCLES;
      repeat (30) send_noise(rand_q16(3 * 65536));
      wait_drained();
   endtask

   // sender goes quiet mid replicate until all results are in, then resumes
   task automatic test_sender_pause();
      apply_config(base_cfg(1, 9, 2));
      repeat (6) send_noise(rand_q16(3 * 65536));
      wait_drained();
      repeat (6) send_noise(rand_q16(3 * 65536));
      wait_drained();
   endtask

   task automatic test_random_runs();
      pop_cfg_type c;
      int          sent;
      int          phase;
      int          burst;
      sent  = 0;
      phase = 0;
      while (sent < 950) begin
         c.growth = rand_q16(4 * 65536);
         case ($urandom_range(0, 5))
            0:       c.scale = '0;
            1:       c.scale = '1;
            2:       c.scale = SCALE_W'($urandom);
            default: c.scale = SCALE_W'($urandom_range(0, 65536));
         endcase
         c.start = rand_q16(3 * 65536);
         case ($urandom_range(0, 5))
            0:       c.burn = '0;
            1:       c.burn = COUNT_W'($urandom_range(7, 40));
            default: c.burn = COUNT_W'($urandom_range(0, 6));
         endcase
         c.kept = ($urandom_range(0, 7) == 0) ? '0 : COUNT_W'($urandom_range(1, 12));
         c.reps = ($urandom_range(0, 7) == 0) ? '0 : COUNT_W'($urandom_range(1, 4));
         apply_config(c);
         // one long phase with neither side idling
         idle_en = (phase != 3);
         burst   = idle_en ? $urandom_range(20, 60) : 150;
         repeat (burst) send_noise(rand_q16(3 * 65536));
         wait_drained();
         sent += burst;
         phase++;
      end
      idle_en = 1'b1;
   endtask

   initial begin
      mismatches      = 0;
      idle_en         = 1'b1;
      rsp_hold_cycles = 0;
      cfg_now         = base_cfg(rlps_pkg::BURN_IN_STEPS_RST, rlps_pkg::KEPT_STEPS_RST,
                                 rlps_pkg::REPLICATE_COUNT_RST);
      x_now           = rlps_pkg::INITIAL_LOG_POP_RST;
      step_idx        = 0;
      rep_idx         = 0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.noise <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_and_retune();
      test_zero_counts();
      test_exp_limits();
      test_sum_saturation();
      test_replicate_cycle();
      test_output_stall();
      test_sender_pause();
      test_random_runs();
      wait_drained();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- ricker_log_population_stepper.f -----
rtl/core/rlps_pkg.sv
rtl/core/rlps_if.sv
rtl/core/ricker_log_population_stepper.sv
dv/ricker_log_population_stepper_test.sv
